@@ rtl/oaht_pkg.sv @@
`timescale 1ns / 1ps

package oaht_pkg;

  // Table geometry and field widths.
  localparam int SLOTS       = 256;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int KEY_BITS    = 31;
  localparam int VALUE_BITS  = 32;
  localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;
  localparam int COUNT_BITS  = 9;
  localparam int ACTION_BITS = 2;
  localparam int STATUS_BITS = 2;

  // Distance between two consecutive probes.
  localparam int PROBE_STEP = 7;

  // Operation codes of an input item.
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  // Status codes of a result item.
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

endpackage

@@ rtl/open_addressing_hash_table_core.sv @@
`timescale 1ns / 1ps

// Key-value table with open addressing and linear probing by a fixed step of 7 slots,
// starting at the key modulo the slot count. Each item (insert/update, lookup or remove)
// is handled by a small sequencer that visits one slot per probe: a probe reads the
// slot's key and value from a single-port memory into a register and compares the key
// in the next cycle, so an item that needs P probes (1 to 256) has its result loaded
// into the output register at the end of its last compare, and the input becomes ready
// as the result becomes valid. If the previous result has not been taken yet,
// the final compare cycle holds until the output register frees up. The input is not
// ready while an item is in progress; a finished result may wait in the output register
// while the next item is accepted. The used and tombstone flags live in flip-flops that
// reset clears at once, so no clearing pass follows reset.
module open_addressing_hash_table_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [oaht_pkg::ACTION_BITS-1:0]     action,
  input  logic [oaht_pkg::KEY_BITS-1:0]        key,
  input  logic signed [oaht_pkg::VALUE_BITS-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [oaht_pkg::STATUS_BITS-1:0]     status,
  output logic signed [oaht_pkg::VALUE_BITS-1:0] found_value,
  output logic [oaht_pkg::COUNT_BITS-1:0]      live_count
);

  oaht_pkg::state_t state;

  // Request held for the duration of the search.
  logic [oaht_pkg::ACTION_BITS-1:0] act_q;
  logic [oaht_pkg::KEY_BITS-1:0]    key_q;
  logic [oaht_pkg::VALUE_BITS-1:0]  val_q;

  // Probe position and number of probes already done.
  logic [oaht_pkg::SLOT_BITS-1:0] slot;
  logic [oaht_pkg::SLOT_BITS-1:0] probe_cnt;

  // Per-slot flags and the live entry count.
  logic [oaht_pkg::SLOTS-1:0]      slot_used;
  logic [oaht_pkg::SLOTS-1:0]      slot_tombstone;
  logic [oaht_pkg::COUNT_BITS-1:0] entry_count;

  // Key and value storage, one entry per slot.
  logic [oaht_pkg::ENTRY_BITS-1:0] entry_mem [oaht_pkg::SLOTS];
  logic [oaht_pkg::ENTRY_BITS-1:0] rd_data;
  logic                            used_q;
  logic                            tomb_q;

  // Decision made in the compare cycle.
  logic                             finish;
  logic                             advance;
  logic                             mem_we;
  logic                             set_used;
  logic                             set_tomb;
  logic                             clr_tomb;
  logic                             cnt_inc;
  logic                             cnt_dec;
  logic [oaht_pkg::STATUS_BITS-1:0] status_next;
  logic [oaht_pkg::VALUE_BITS-1:0]  found_next;

  logic key_match;
  logic last_probe;
  logic out_free;

  assign key_match  = (rd_data[oaht_pkg::ENTRY_BITS-1:oaht_pkg::VALUE_BITS] == key_q);
  assign last_probe = (probe_cnt == oaht_pkg::SLOT_BITS'(oaht_pkg::SLOTS - 1));
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == oaht_pkg::S_IDLE);

  // Compare the probed slot against the request and choose what to do.
  always_comb begin
    finish      = 1'b0;
    advance     = 1'b0;
    mem_we      = 1'b0;
    set_used    = 1'b0;
    set_tomb    = 1'b0;
    clr_tomb    = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    status_next = oaht_pkg::STAT_OK;
    found_next  = '0;
    case (act_q)
      oaht_pkg::ACT_INSERT: begin
        if (!used_q) begin
          finish   = 1'b1;
          mem_we   = 1'b1;
          set_used = 1'b1;
          clr_tomb = 1'b1;
          cnt_inc  = 1'b1;
        end else if (key_match) begin
          finish   = 1'b1;
          mem_we   = 1'b1;
          clr_tomb = tomb_q;
          cnt_inc  = tomb_q;
        end else if (last_probe) begin
          finish      = 1'b1;
          status_next = oaht_pkg::STAT_FULL;
        end else begin
          advance = 1'b1;
        end
      end
      oaht_pkg::ACT_LOOKUP, oaht_pkg::ACT_REMOVE: begin
        if (!used_q || (key_match && tomb_q) || (!key_match && last_probe)) begin
          finish      = 1'b1;
          status_next = oaht_pkg::STAT_NOTFOUND;
        end else if (key_match) begin
          finish = 1'b1;
          if (act_q == oaht_pkg::ACT_LOOKUP) begin
            found_next = rd_data[oaht_pkg::VALUE_BITS-1:0];
          end else begin
            set_tomb = 1'b1;
            cnt_dec  = (entry_count != '0);
          end
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  // Sequencer, flags, count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= oaht_pkg::S_IDLE;
      slot_used      <= '0;
      slot_tombstone <= '0;
      entry_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        oaht_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= oaht_pkg::S_READ;
          end
        end
        oaht_pkg::S_READ: begin
          state <= oaht_pkg::S_CHECK;
        end
        oaht_pkg::S_CHECK: begin
          if (advance) begin
            state <= oaht_pkg::S_READ;
          end else if (finish && out_free) begin
            state     <= oaht_pkg::S_IDLE;
            out_valid <= 1'b1;
            if (set_used) begin
              slot_used[slot] <= 1'b1;
            end
            if (set_tomb) begin
              slot_tombstone[slot] <= 1'b1;
            end else if (clr_tomb) begin
              slot_tombstone[slot] <= 1'b0;
            end
            if (cnt_inc) begin
              entry_count <= entry_count + oaht_pkg::COUNT_BITS'(1);
            end else if (cnt_dec) begin
              entry_count <= entry_count - oaht_pkg::COUNT_BITS'(1);
            end
          end
        end
        default: begin
          state <= oaht_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Request capture, probe position and result payload.
  always_ff @(posedge clk) begin
    if (state == oaht_pkg::S_IDLE && in_valid) begin
      act_q     <= action;
      key_q     <= key;
      val_q     <= value;
      slot      <= key[oaht_pkg::SLOT_BITS-1:0];
      probe_cnt <= '0;
    end
    if (state == oaht_pkg::S_CHECK && advance) begin
      slot      <= slot + oaht_pkg::SLOT_BITS'(oaht_pkg::PROBE_STEP);
      probe_cnt <= probe_cnt + oaht_pkg::SLOT_BITS'(1);
    end
    if (state == oaht_pkg::S_CHECK && finish && out_free) begin
      status      <= status_next;
      found_value <= found_next;
      live_count  <= cnt_inc ? entry_count + oaht_pkg::COUNT_BITS'(1) :
                     cnt_dec ? entry_count - oaht_pkg::COUNT_BITS'(1) : entry_count;
    end
  end

  // Entry memory: one read or one write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (state == oaht_pkg::S_CHECK && finish && out_free && mem_we) begin
      entry_mem[slot] <= {key_q, val_q};
    end
    if (state == oaht_pkg::S_READ) begin
      rd_data <= entry_mem[slot];
      used_q  <= slot_used[slot];
      tomb_q  <= slot_tombstone[slot];
    end
  end

  // The live count always equals the number of used slots that are not tombstones.
  assert property (@(posedge clk) disable iff (rst)
    entry_count == oaht_pkg::COUNT_BITS'($countones(slot_used & ~slot_tombstone)))
    else $error("live count does not match the slot flags");

  // A tombstone only ever marks a used slot.
  assert property (@(posedge clk) disable iff (rst)
    (slot_tombstone & ~slot_used) == '0)
    else $error("tombstone set on an unused slot");

  // A new result is only loaded at the end of a compare cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == oaht_pkg::S_CHECK))
    else $error("result appeared outside a compare cycle");

  // A probe read is followed by its compare, and the input stays closed meanwhile.
  assert property (@(posedge clk) disable iff (rst)
    (state == oaht_pkg::S_READ) |=> (state == oaht_pkg::S_CHECK) && !in_ready)
    else $error("probe read not followed by compare");

endmodule
